/* rtl/hrfe_pkg.sv */
`timescale 1ns / 1ps

package hrfe_pkg;

  // Result kinds
  localparam logic [2:0] KIND_MBYTE  = 3'd0;
  localparam logic [2:0] KIND_MEND   = 3'd1;
  localparam logic [2:0] KIND_TBYTE  = 3'd2;
  localparam logic [2:0] KIND_TEND   = 3'd3;
  localparam logic [2:0] KIND_VBYTE  = 3'd4;
  localparam logic [2:0] KIND_DONE   = 3'd5;
  localparam logic [2:0] KIND_NONE   = 3'd6;
  localparam logic [2:0] KIND_UNTERM = 3'd7;

  // Configuration register indexes
  localparam logic CFG_IDX_NAME = 1'b0;
  localparam logic CFG_IDX_LEN  = 1'b1;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Most results one input byte can cause
  localparam int MAX_RES = 6;

  // All results caused by one input byte, in order
  typedef struct packed {
    logic [2:0]                 count;
    logic [MAX_RES-1:0][2:0]    kind;
    logic [MAX_RES-1:0][7:0]    data;
  } res_bundle_t;

endpackage

/* rtl/hrfe_ifs.sv */
`timescale 1ns / 1ps

interface hrfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       final_byte;
  modport source (output valid, byte_in, final_byte, input ready);
  modport sink   (input valid, byte_in, final_byte, output ready);
endinterface

interface hrfe_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       last_of_run;
  modport source (output valid, kind, data_byte, last_of_run, input ready);
  modport sink   (input valid, kind, data_byte, last_of_run, output ready);
endinterface

interface hrfe_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/hrfe_front.sv */
`timescale 1ns / 1ps

module hrfe_front #(
  parameter int NAME_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hrfe_in_if.sink              in_ch,
  hrfe_cfg_if.sink             cfg_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output hrfe_pkg::res_bundle_t q_data
);

  localparam int IW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int SW = $clog2(NAME_BYTES + 1);

  typedef enum logic [1:0] {LP_METHOD, LP_TARGET, LP_DONE} line_phase_t;
  typedef enum logic [1:0] {HP_SEARCH, HP_COLON, HP_VALUE, HP_FOUND} header_phase_t;

  // Append one result to a bundle
  function automatic hrfe_pkg::res_bundle_t add_res(hrfe_pkg::res_bundle_t b,
                                                    logic [2:0] k, logic [7:0] d);
    hrfe_pkg::res_bundle_t r;
    r = b;
    r.kind[b.count] = k;
    r.data[b.count] = d;
    r.count = b.count + 3'd1;
    return r;
  endfunction

  // Close any open method or target
  function automatic hrfe_pkg::res_bundle_t close_res(hrfe_pkg::res_bundle_t b,
                                                      line_phase_t lp);
    hrfe_pkg::res_bundle_t r;
    r = b;
    case (lp)
      LP_METHOD: begin
        r = add_res(r, hrfe_pkg::KIND_MEND, hrfe_pkg::CH_NUL);
        r = add_res(r, hrfe_pkg::KIND_TEND, hrfe_pkg::CH_NUL);
      end
      LP_TARGET: r = add_res(r, hrfe_pkg::KIND_TEND, hrfe_pkg::CH_NUL);
      default: ;
    endcase
    return r;
  endfunction

  logic [63:0]                 name_r;
  logic [3:0]                  len_r;
  line_phase_t                 line_phase_r, lp;
  header_phase_t               header_phase_r, hp;
  logic                        cr_held_r, cr;
  logic                        ended_r, ended;
  logic [SW-1:0]               seen_r, seen;
  logic [NAME_BYTES-1:0][7:0]  recent_r;
  logic [NAME_BYTES:0][7:0]    cat_w;
  logic [NAME_BYTES-1:0][7:0]  window_w;
  logic [3:0]                  len_eff;
  logic                        name_hit;
  logic                        accept;
  logic [7:0]                  b;
  hrfe_pkg::res_bundle_t       res;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign b           = in_ch.byte_in;

  // Window of the newest bytes, incoming byte lowest
  assign cat_w    = {recent_r, b};
  assign window_w = cat_w[NAME_BYTES-1:0];

  // Clamp the name length to 1..NAME_BYTES
  always_comb begin
    if (len_r == 4'd0) begin
      len_eff = 4'd1;
    end else if (len_r > 4'(NAME_BYTES)) begin
      len_eff = 4'(NAME_BYTES);
    end else begin
      len_eff = len_r;
    end
  end

  // Compare the name against the window ending at the incoming byte
  always_comb begin
    logic [3:0] back;
    logic [7:0] want;
    logic [7:0] have;
    back = 4'd0;
    want = 8'd0;
    have = 8'd0;
    name_hit = ({1'b0, 4'(seen_r)} + 5'd1) >= {1'b0, len_eff};
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (4'(k) < len_eff) begin
        back = len_eff - 4'd1 - 4'(k);
        want = name_r[8*k +: 8];
        have = window_w[back[IW-1:0]];
        if (want != have || want == hrfe_pkg::CH_NUL) begin
          name_hit = 1'b0;
        end
      end
    end
  end

  // Classify the byte and build its result bundle
  always_comb begin
    lp    = line_phase_r;
    hp    = header_phase_r;
    cr    = cr_held_r;
    ended = ended_r;
    seen  = seen_r;
    res   = '0;
    if (!ended_r) begin
      if (b == hrfe_pkg::CH_NUL) begin
        res   = close_res(res, lp);
        lp    = LP_DONE;
        ended = 1'b1;
      end else begin
        case (line_phase_r)
          LP_METHOD: begin
            if (b == hrfe_pkg::CH_SPACE) begin
              res = add_res(res, hrfe_pkg::KIND_MEND, hrfe_pkg::CH_NUL);
              lp  = LP_TARGET;
            end else begin
              res = add_res(res, hrfe_pkg::KIND_MBYTE, b);
            end
          end
          LP_TARGET: begin
            if (b == hrfe_pkg::CH_SPACE) begin
              res = add_res(res, hrfe_pkg::KIND_TEND, hrfe_pkg::CH_NUL);
              lp  = LP_DONE;
            end else begin
              res = add_res(res, hrfe_pkg::KIND_TBYTE, b);
            end
          end
          default: ;
        endcase
        case (header_phase_r)
          HP_SEARCH: begin
            if (name_hit) hp = HP_COLON;
          end
          HP_COLON: begin
            if (b == hrfe_pkg::CH_COLON) hp = HP_VALUE;
          end
          HP_VALUE: begin
            if (cr_held_r) begin
              if (b == hrfe_pkg::CH_LF) begin
                cr = 1'b0;
                hp = HP_FOUND;
              end else begin
                res = add_res(res, hrfe_pkg::KIND_VBYTE, hrfe_pkg::CH_CR);
                if (b == hrfe_pkg::CH_CR) begin
                  cr = 1'b1;
                end else begin
                  res = add_res(res, hrfe_pkg::KIND_VBYTE, b);
                  cr  = 1'b0;
                end
              end
            end else if (b == hrfe_pkg::CH_CR) begin
              cr = 1'b1;
            end else begin
              res = add_res(res, hrfe_pkg::KIND_VBYTE, b);
            end
          end
          default: ;
        endcase
        if (seen_r < SW'(NAME_BYTES)) seen = seen_r + SW'(1);
      end
    end
    // Last byte: close the line, report, clear the request
    if (in_ch.final_byte) begin
      res = close_res(res, lp);
      case (hp)
        HP_FOUND:  res = add_res(res, hrfe_pkg::KIND_DONE, hrfe_pkg::CH_NUL);
        HP_SEARCH: res = add_res(res, hrfe_pkg::KIND_NONE, hrfe_pkg::CH_NUL);
        default:   res = add_res(res, hrfe_pkg::KIND_UNTERM, hrfe_pkg::CH_NUL);
      endcase
      lp    = LP_METHOD;
      hp    = HP_SEARCH;
      cr    = 1'b0;
      ended = 1'b0;
      seen  = '0;
    end
  end

  assign q_push = accept && (res.count != 3'd0);
  assign q_data = res;

  // Hold request state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_phase_r   <= LP_METHOD;
      header_phase_r <= HP_SEARCH;
      cr_held_r      <= 1'b0;
      ended_r        <= 1'b0;
      seen_r         <= '0;
    end else if (accept) begin
      line_phase_r   <= lp;
      header_phase_r <= hp;
      cr_held_r      <= cr;
      ended_r        <= ended;
      seen_r         <= seen;
    end
  end

  // Shift the byte window on each accepted byte before the request has ended, except a zero byte
  always_ff @(posedge clk) begin
    if (accept && !ended_r && b != hrfe_pkg::CH_NUL) begin
      recent_r <= window_w;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r <= '0;
      len_r  <= 4'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        hrfe_pkg::CFG_IDX_NAME: name_r <= cfg_ch.data;
        hrfe_pkg::CFG_IDX_LEN:  len_r  <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/hrfe_fifo.sv */
`timescale 1ns / 1ps

module hrfe_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  hrfe_pkg::res_bundle_t wr_data,
  output logic                  full,
  input  logic                  pop,
  output hrfe_pkg::res_bundle_t rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hrfe_pkg::res_bundle_t entry_r [DEPTH];
  logic [AW-1:0]         wr_ptr_r;
  logic [AW-1:0]         rd_ptr_r;
  logic [AW:0]           cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = entry_r[rd_ptr_r];

  // Store a bundle at the write pointer
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= wr_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/hrfe_back.sv */
`timescale 1ns / 1ps

module hrfe_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  hrfe_pkg::res_bundle_t q_head,
  output logic                  q_pop,
  hrfe_out_if.source            out_ch
);

  logic [2:0] idx_r;
  logic       last;
  logic       accept;

  assign last   = (idx_r == q_head.count - 3'd1);
  assign accept = out_ch.valid && out_ch.ready;

  // Present the current result of the head bundle
  assign out_ch.valid       = !q_empty;
  assign out_ch.kind        = q_head.kind[idx_r];
  assign out_ch.data_byte   = q_head.data[idx_r];
  assign out_ch.last_of_run = last;

  // Drop the bundle after its final beat
  assign q_pop = accept && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else if (accept) begin
      idx_r <= last ? 3'd0 : idx_r + 3'd1;
    end
  end

endmodule

/* rtl/http_request_field_extractor.sv */
`timescale 1ns / 1ps

// HTTP request field extractor. Bytes of a request enter one per cycle on in_ch; the
// block emits the method and target of the request line as tagged bytes with end
// markers, finds the first occurrence of the configured header name (which must be
// written on cfg_ch while idle, a rule the block leaves to the user) and emits that
// header's value up to CR LF, then on the beat marked final_byte reports value complete,
// not found or unterminated and clears for the next request. A zero byte ends the request
// early. A new byte is accepted every cycle while the internal result queue has room;
// each byte yields zero to six results, which leave on out_ch one per cycle while out_ch
// is ready. The QUEUE_DEPTH-entry queue between the classifier and the output sequencer
// lets input and output stall independently.
module http_request_field_extractor #(
  parameter int NAME_BYTES  = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  hrfe_in_if.sink     in_ch,
  hrfe_out_if.source  out_ch,
  hrfe_cfg_if.sink    cfg_ch
);

  hrfe_pkg::res_bundle_t push_data;
  hrfe_pkg::res_bundle_t head_data;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  empty;

  hrfe_front #(
    .NAME_BYTES (NAME_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  hrfe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_data),
    .full    (full),
    .pop     (pop),
    .rd_data (head_data),
    .empty   (empty)
  );

  hrfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (empty),
    .q_head  (head_data),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule
